### hdl/dpms_pkg.sv
// package: constants, types and helpers shared by the pendulum step core
`timescale 1ns / 1ps
package dpms_pkg;

   localparam int FracBitsDefault = 24;
   localparam int TrigIterDefault = 24;

   localparam logic [24:0] StepSizeReset = 25'd167772;
   localparam logic signed [31:0] DampingReset = 32'sd8388608;
   localparam logic signed [31:0] GravityReset = 32'sd16777216;
   localparam logic signed [31:0] AmplitudeReset = 32'sd15099494;
   localparam logic signed [31:0] FrequencyReset = 32'sd8053064;
   localparam logic signed [31:0] InitAngleReset = 32'sd16777216;
   localparam logic signed [31:0] InitVelocityReset = 32'sd0;

   localparam logic signed [33:0] PhaseScale = 34'sd2734261102;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   localparam logic [15:0] CountMax = 16'hFFFF;

   typedef enum logic [2:0] {
      REG_STEP_SIZE = 3'd0,
      REG_DAMPING = 3'd1,
      REG_GRAVITY = 3'd2,
      REG_AMPLITUDE = 3'd3,
      REG_FREQUENCY = 3'd4,
      REG_INIT_ANGLE = 3'd5,
      REG_INIT_VELOCITY = 3'd6
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TAU, ST_K1_P, ST_K1_T, ST_K1_FIN, ST_VM, ST_PM, ST_K2_P,
      ST_K2_T, ST_K2_FIN, ST_NA, ST_NV, ST_TIME, ST_OUT
   } state_type;

   // accel sub-sequence phases
   typedef enum logic [3:0] {
      AC_SIN1, AC_WAIT1, AC_WT, AC_SIN2, AC_WAIT2, AC_QV, AC_GS, AC_AC, AC_DONE
   } acc_phase_type;

   typedef struct packed {
      logic start;
      logic signed [31:0] arg;
   } cordic_req_type;

   typedef struct packed {
      logic done;
      logic signed [31:0] sin_val;
      logic signed [31:0] cos_val;
   } cordic_rsp_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
         5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
         5'd20: r = 32'd652;       5'd21: r = 32'd326;
         5'd22: r = 32'd163;       5'd23: r = 32'd81;
         5'd24: r = 32'd41;        5'd25: r = 32'd20;
         5'd26: r = 32'd10;        5'd27: r = 32'd5;
         5'd28: r = 32'd3;         5'd29: r = 32'd1;
         5'd30: r = 32'd1;         default: r = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > 66'sd2147483647) r = 32'h7FFFFFFF;
      else if (x < -66'sd2147483648) r = 32'h80000000;
      else r = x[31:0];
      return r;
   endfunction

endpackage

### hdl/dpms_cordic.sv
// shared rotation-mode cordic unit, one micro-rotation per cycle
`timescale 1ns / 1ps
module dpms_cordic
   import dpms_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault,
   parameter int TRIG_ITERATIONS = TrigIterDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  cordic_req_type req,
   output cordic_rsp_type rsp
);
   localparam int NIter = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
   localparam int RShift = 30 - FRAC_BITS;

   logic busy_ff, busy_in, done_ff, done_in, flip_ff, flip_in;
   logic [4:0] iter_ff, iter_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic signed [65:0] prod;
   logic [31:0] ph, ph0;
   logic signed [33:0] dx, dy;
   logic signed [34:0] xr, yr;

   always_comb begin
      prod = 66'(req.arg) * 66'(PhaseScale);
      ph0 = prod[FRAC_BITS+33:FRAC_BITS+2];
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      iter_in = iter_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      ph = ph0;
      if (req.start) begin
         flip_in = 1'b0;
         if (ph0[31] ^ ph0[30]) begin
            ph = ph0 - 32'h80000000;
            flip_in = 1'b1;
         end
         z_in = 33'($signed(ph));
         x_in = CordicGain;
         y_in = '0;
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - 33'(atan_turn(iter_ff));
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + 33'(atan_turn(iter_ff));
         end
         iter_in = iter_ff + 5'd1;
         if (32'(iter_ff) == NIter - 1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff <= flip_in;
      iter_ff <= iter_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   always_comb begin
      if (RShift == 0) begin
         xr = 35'(x_ff);
         yr = 35'(y_ff);
      end else begin
         xr = (35'(x_ff) + (35'sd1 <<< (RShift - 1))) >>> RShift;
         yr = (35'(y_ff) + (35'sd1 <<< (RShift - 1))) >>> RShift;
      end
      rsp.done = done_ff;
      rsp.cos_val = sat32(flip_ff ? -66'(xr) : 66'(xr));
      rsp.sin_val = sat32(flip_ff ? -66'(yr) : 66'(yr));
   end

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("cordic done lasted two cycles");
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy_ff) else $error("cordic did not start");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("cordic done while busy");
endmodule

### hdl/driven_pendulum_midpoint_step_core.sv
// top level: midpoint step sequencer over one shared multiplier and one cordic unit
`timescale 1ns / 1ps
// channel | dir | ready/valid    | payload
// req     | in  | req_tready     | tdata[0] restart
// rsp     | out | rsp_tvalid     | tdata step_index, sim_time, angle, angular_velocity
// csr     | in  | write enable   | index 3 bits, data 32 bits
// a step runs four cordic jobs, two for each acceleration, and does the remaining products on
// the shared 32x32 multiplier; a restart only reloads the initial state and the time
// req_tready is high only in idle; one transaction in flight at a time
// reset is synchronous and loads the register defaults and initial state
// a held result stalls the sequencer in its output state until rsp_tready
module driven_pendulum_midpoint_step_core
   import dpms_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault,
   parameter int TRIG_ITERATIONS = TrigIterDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [0] restart
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // step_index, sim_time, angle, angular_velocity
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   logic [24:0] h_ff;
   logic signed [31:0] q_ff, g_ff, a_ff, w_ff, ia_ff, iv_ff;
   logic [15:0] cnt_ff, cnt_in;
   logic signed [31:0] ang_ff, ang_in, vel_ff, vel_in;
   logic signed [31:0] tau_ff, tau_in, k1_ff, k1_in, vm_ff, vm_in, pm_ff, pm_in;
   // acceleration sum kept wide, saturated once after the last term
   logic signed [33:0] acc_ff, acc_in;
   logic signed [31:0] s1_ff, s1_in, c2_ff, c2_in;
   logic signed [31:0] na_ff, na_in, tm_ff, tm_in;
   state_type st_ff, st_in;
   acc_phase_type ap_ff, ap_in;
   logic [111:0] out_ff, out_in;
   logic ov_ff, ov_in;
   cordic_req_type creq;
   cordic_rsp_type crsp;

   // shared multiplier: operands selected by the sequencer
   logic signed [32:0] ma, mb;
   logic signed [65:0] mp, mr;
   logic signed [31:0] mres, mraw, hh;
   logic signed [31:0] acc_tau, acc_pos, acc_vel;

   dpms_cordic #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
      .clock(clock), .reset(reset), .req(creq), .rsp(crsp));

   assign hh = 32'(h_ff >> 1);
   assign mp = 66'(ma) * 66'(mb);
   assign mr = (mp + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   assign mres = sat32(mr);
   // time is a plain count times step product, no fraction shift
   assign mraw = sat32(mp);

   logic acc_phase_on;
   assign acc_phase_on = (st_ff == ST_K1_P) || (st_ff == ST_K2_P);
   always_comb begin
      if (st_ff == ST_K1_P) begin
         acc_tau = tau_ff; acc_pos = ang_ff; acc_vel = vel_ff;
      end else begin
         acc_tau = sat32(66'(tau_ff) + 66'(hh)); acc_pos = pm_ff; acc_vel = vm_ff;
      end
   end

   always_comb begin
      ma = '0;
      mb = '0;
      case (st_ff)
         ST_TAU, ST_TIME: begin ma = 33'(cnt_ff); mb = 33'(h_ff); end
         ST_VM: begin ma = 33'(hh); mb = 33'(k1_ff); end
         ST_PM: begin ma = 33'(hh); mb = 33'(vel_ff); end
         ST_NA: begin ma = 33'(h_ff); mb = 33'(vm_ff); end
         ST_NV: begin ma = 33'(h_ff); mb = 33'(acc_ff); end
         ST_K1_P, ST_K2_P: begin
            case (ap_ff)
               AC_WT: begin ma = 33'(w_ff); mb = 33'(acc_tau); end
               AC_QV: begin ma = 33'(q_ff); mb = 33'(acc_vel); end
               AC_GS: begin ma = 33'(g_ff); mb = 33'(s1_ff); end
               AC_AC: begin ma = 33'(a_ff); mb = 33'(c2_ff); end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      st_in = st_ff;
      ap_in = ap_ff;
      case (st_ff)
         ST_IDLE: if (req_tvalid && req_tready) st_in = req_tdata[0] ? ST_TIME : ST_TAU;
         ST_TAU: begin st_in = ST_K1_P; ap_in = AC_SIN1; end
         ST_K1_P, ST_K2_P: begin
            case (ap_ff)
               AC_SIN1: ap_in = AC_WAIT1;
               AC_WAIT1: if (crsp.done) ap_in = AC_WT;
               AC_WT: ap_in = AC_SIN2;
               AC_SIN2: ap_in = AC_WAIT2;
               AC_WAIT2: if (crsp.done) ap_in = AC_QV;
               AC_QV: ap_in = AC_GS;
               AC_GS: ap_in = AC_AC;
               AC_AC: ap_in = AC_DONE;
               default: st_in = (st_ff == ST_K1_P) ? ST_VM : ST_NA;
            endcase
         end
         ST_VM: st_in = ST_PM;
         ST_PM: begin st_in = ST_K2_P; ap_in = AC_SIN1; end
         ST_NA: st_in = ST_NV;
         ST_NV: st_in = ST_TIME;
         ST_TIME: st_in = ST_OUT;
         ST_OUT: if (!ov_ff) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      cnt_in = cnt_ff; ang_in = ang_ff; vel_in = vel_ff;
      tau_in = tau_ff; k1_in = k1_ff; vm_in = vm_ff; pm_in = pm_ff;
      acc_in = acc_ff; s1_in = s1_ff; c2_in = c2_ff; na_in = na_ff; tm_in = tm_ff;
      out_in = out_ff;
      ov_in = ov_ff && !rsp_tready;
      creq.start = 1'b0;
      creq.arg = acc_pos;
      if (acc_phase_on && ap_ff == AC_SIN2) creq.arg = tm_ff;
      case (st_ff)
         ST_IDLE: if (req_tvalid && req_tready && req_tdata[0]) begin
            cnt_in = '0; ang_in = ia_ff; vel_in = iv_ff;
         end
         ST_TAU: tau_in = mraw;
         ST_K1_P, ST_K2_P: begin
            case (ap_ff)
               AC_SIN1: creq.start = 1'b1;
               AC_WAIT1: if (crsp.done) s1_in = crsp.sin_val;
               AC_WT: tm_in = mres;
               AC_SIN2: creq.start = 1'b1;
               AC_WAIT2: if (crsp.done) c2_in = crsp.cos_val;
               AC_QV: acc_in = -34'(mres);
               AC_GS: acc_in = acc_ff - 34'(mres);
               AC_AC: acc_in = 34'(sat32(66'(acc_ff) + 66'(mres)));
               default: if (st_ff == ST_K1_P) k1_in = acc_ff[31:0];
            endcase
         end
         ST_VM: vm_in = sat32(66'(vel_ff) + 66'(mres));
         ST_PM: pm_in = sat32(66'(ang_ff) + 66'(mres));
         ST_NA: na_in = sat32(66'(ang_ff) + 66'(mres));
         ST_NV: begin
            ang_in = na_ff;
            vel_in = sat32(66'(vel_ff) + 66'(mres));
            if (cnt_ff != CountMax) cnt_in = cnt_ff + 16'd1;
         end
         ST_TIME: tm_in = mraw;
         ST_OUT: if (!ov_ff) begin
            out_in = {vel_ff, ang_ff, tm_ff, cnt_ff};
            ov_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ap_ff <= AC_SIN1;
         ov_ff <= 1'b0;
         cnt_ff <= '0;
         ang_ff <= InitAngleReset;
         vel_ff <= InitVelocityReset;
         h_ff <= StepSizeReset;
         q_ff <= DampingReset;
         g_ff <= GravityReset;
         a_ff <= AmplitudeReset;
         w_ff <= FrequencyReset;
         ia_ff <= InitAngleReset;
         iv_ff <= InitVelocityReset;
      end else begin
         st_ff <= st_in;
         ap_ff <= ap_in;
         ov_ff <= ov_in;
         cnt_ff <= cnt_in;
         ang_ff <= ang_in;
         vel_ff <= vel_in;
         if (csr_we) begin
            case (csr_index)
               REG_STEP_SIZE: h_ff <= csr_data[24:0];
               REG_DAMPING: q_ff <= csr_data;
               REG_GRAVITY: g_ff <= csr_data;
               REG_AMPLITUDE: a_ff <= csr_data;
               REG_FREQUENCY: w_ff <= csr_data;
               REG_INIT_ANGLE: ia_ff <= csr_data;
               REG_INIT_VELOCITY: iv_ff <= csr_data;
               default: ;
            endcase
         end
      end
      tau_ff <= tau_in; k1_ff <= k1_in; vm_ff <= vm_in; pm_ff <= pm_in;
      acc_ff <= acc_in; s1_ff <= s1_in; c2_ff <= c2_in; na_ff <= na_in; tm_ff <= tm_in;
      out_ff <= out_in;
   end

   // outputs
   always_comb begin
      req_tready = (st_ff == ST_IDLE);
      rsp_tvalid = ov_ff;
      rsp_tdata = out_ff;
   end

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("accepted during work");
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_NV && cnt_ff == CountMax) |=> cnt_ff == CountMax)
      else $error("step count wrapped");
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_OUT && !ov_ff) |=> rsp_tvalid) else $error("result not presented");
endmodule

### bench/tb.sv
// testbench for the pendulum midpoint step core: predicts each step and checks every result
`timescale 1ns / 1ps
module tb;
   import dpms_pkg::*;

   localparam logic [2:0] UNUSED_INDEX = 3'd7;
   localparam int FRAC = FracBitsDefault;
   localparam int TRIG_STEPS = TrigIterDefault;
   localparam longint SMAX = 64'sd2147483647;
   localparam longint SMIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] angular_velocity;
      logic signed [31:0] angle;
      logic signed [31:0] sim_time;
      logic [15:0]        step_index;
   } step_result_type;

   // midpoint pendulum predictor with its own copy of registers and state
   class pendulum_scoreboard;
      longint h, q, g, amp, freq, init_a, init_v;
      int unsigned count;
      longint ang, vel;
      step_result_type pending_steps[$];
      int errors;
      longint atan_tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
         21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
         41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

      function new();
         h = StepSizeReset; q = DampingReset; g = GravityReset; amp = AmplitudeReset;
         freq = FrequencyReset; init_a = InitAngleReset; init_v = InitVelocityReset;
         count = 0; ang = init_a; vel = init_v; errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_STEP_SIZE: h = longint'({7'd0, v[24:0]});
            REG_DAMPING: q = longint'(signed'(v));
            REG_GRAVITY: g = longint'(signed'(v));
            REG_AMPLITUDE: amp = longint'(signed'(v));
            REG_FREQUENCY: freq = longint'(signed'(v));
            REG_INIT_ANGLE: init_a = longint'(signed'(v));
            REG_INIT_VELOCITY: init_v = longint'(signed'(v));
            default: ;
         endcase
      endfunction

      function longint clip(longint x);
         return (x > SMAX) ? SMAX : (x < SMIN) ? SMIN : x;
      endfunction

      function longint fmul(longint x, longint y);
         return clip((x * y + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
      endfunction

      function void trig(longint arg, output longint sn, output longint cs);
         logic [31:0] ph;
         logic [31:0] rot;
         bit flip;
         longint z, x, y, dx, dy;
         ph = 32'((arg * longint'(PhaseScale)) >>> (FRAC + 2));
         rot = ph + 32'h40000000;
         flip = rot[31];
         if (flip) ph = ph - 32'h80000000;
         z = longint'(signed'(ph));
         x = longint'(CordicGain);
         y = 0;
         for (int i = 0; i < TRIG_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_tab[i];
            end else begin
               x += dx; y -= dy; z += atan_tab[i];
            end
         end
         x = (x + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
         y = (y + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
         cs = clip(flip ? -x : x);
         sn = clip(flip ? -y : y);
      endfunction

      function longint acceleration(longint tau, longint p, longint v);
         longint s, c, s2, c2;
         trig(p, s, c);
         trig(fmul(freq, tau), s2, c2);
         return clip(-fmul(q, v) - fmul(g, s) + fmul(amp, c2));
      endfunction

      function void note_request(bit restart);
         longint hh, tau, k1, vm, pm, k2, na, nv;
         step_result_type r;
         if (restart) begin
            count = 0; ang = init_a; vel = init_v;
         end else begin
            hh = h >>> 1;
            tau = clip(longint'(count) * h);
            k1 = acceleration(tau, ang, vel);
            vm = clip(vel + fmul(hh, k1));
            pm = clip(ang + fmul(hh, vel));
            k2 = acceleration(clip(tau + hh), pm, vm);
            na = clip(ang + fmul(h, vm));
            nv = clip(vel + fmul(h, k2));
            ang = na; vel = nv;
            if (count < int'(CountMax)) count++;
         end
         r.step_index = 16'(count);
         r.sim_time = 32'(clip(longint'(count) * h));
         r.angle = 32'(ang);
         r.angular_velocity = 32'(vel);
         pending_steps = {pending_steps, r};
      endfunction

      function void check_result(logic [111:0] data);
         step_result_type got, want;
         got = data;
         if (pending_steps.size() == 0) begin
            $error("unexpected result transaction %h", data);
            errors++;
            return;
         end
         want = pending_steps.pop_front();
         if (got.step_index !== want.step_index) begin
            $error("step_index exp %0d got %0d", want.step_index, got.step_index); errors++;
         end
         if (got.sim_time !== want.sim_time) begin
            $error("sim_time exp %0d got %0d", want.sim_time, got.sim_time); errors++;
         end
         if (got.angle !== want.angle) begin
            $error("angle exp %0d got %0d", want.angle, got.angle); errors++;
         end
         if (got.angular_velocity !== want.angular_velocity) begin
            $error("angular_velocity exp %0d got %0d", want.angular_velocity,
                   got.angular_velocity);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [7:0] req_tdata = 0;   // [0] restart
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [111:0] rsp_tdata;     // step_index, sim_time, angle, angular_velocity
   logic csr_we = 0;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   pendulum_scoreboard sb = new();
   bit gaps_on = 1;

   driven_pendulum_midpoint_step_core u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_data
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb: FAIL");
      $finish;
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      csr_we <= 0;
      sb.set_reg(idx, v);
   endtask

   task automatic send_step(bit restart);
      int gap;
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'd0, restart};
      do @(posedge clock); while (!req_tready);
      sb.note_request(restart);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      do @(posedge clock); while (sb.pending_steps.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] coef();
      return (($urandom_range(0, 1)) ? 32'($urandom_range(0, 32'h04000000))
              : -32'($urandom_range(0, 32'h04000000)));
   endfunction

   // result side: random stalls, checked on every handshake
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = gaps_on ? $urandom_range(0, 7) : 0;
         if (n > 0) begin
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: default settings, restart, steps, unused register
      send_step(1);
      repeat (8) send_step(0);
      send_step(1);
      repeat (3) send_step(0);
      drain();
      write_reg(UNUSED_INDEX, 32'hFFFFFFFF);
      send_step(0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         gaps_on = (ph != 4);
         case (ph)
            0: begin
               write_reg(REG_STEP_SIZE, 32'd0);
               write_reg(REG_DAMPING, coef()); write_reg(REG_GRAVITY, coef());
               write_reg(REG_AMPLITUDE, coef()); write_reg(REG_FREQUENCY, coef());
               write_reg(REG_INIT_ANGLE, $urandom); write_reg(REG_INIT_VELOCITY, coef());
            end
            1: begin
               write_reg(REG_STEP_SIZE, 32'd16777216);
               write_reg(REG_DAMPING, 32'h7FFFFFFF); write_reg(REG_GRAVITY, 32'h7FFFFFFF);
               write_reg(REG_AMPLITUDE, 32'h7FFFFFFF); write_reg(REG_FREQUENCY, 32'h7FFFFFFF);
               write_reg(REG_INIT_ANGLE, 32'h7FFFFFFF);
               write_reg(REG_INIT_VELOCITY, 32'h7FFFFFFF);
            end
            2: begin
               // upper data bits are beyond the step size register
               write_reg(REG_STEP_SIZE, $urandom | 32'h01FFFFFF);
               write_reg(REG_DAMPING, 32'h80000000); write_reg(REG_GRAVITY, 32'h80000000);
               write_reg(REG_AMPLITUDE, 32'h80000000); write_reg(REG_FREQUENCY, 32'h80000000);
               write_reg(REG_INIT_ANGLE, 32'h80000000);
               write_reg(REG_INIT_VELOCITY, 32'h80000000);
            end
            default: begin
               write_reg(REG_STEP_SIZE, (ph == 7) ? $urandom : $urandom_range(0, 1 << 21));
               write_reg(REG_DAMPING, coef()); write_reg(REG_GRAVITY, coef());
               write_reg(REG_AMPLITUDE, coef()); write_reg(REG_FREQUENCY, $urandom);
               write_reg(REG_INIT_ANGLE, $urandom); write_reg(REG_INIT_VELOCITY, $urandom);
            end
         endcase
         send_step(1);
         for (int i = 0; i < 140; i++) send_step($urandom_range(0, 15) == 0);
         drain();
      end

      do @(posedge clock); while (sb.pending_steps.size() != 0);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_steps.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
